// ----- src/pcbs_pkg.sv -----
// Shared constants and controller/datapath interface types for the box suppression block.
package pcbs_pkg;

    localparam int MAX_CANDIDATES_DEF = 64;
    localparam int COORD_BITS_DEF     = 12;
    localparam int CLASS_W            = 8;
    localparam int SCORE_W            = 16;
    localparam int THR_W              = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // request accepted this cycle
        logic scan_start;  // begin a pass over the stored candidates
        logic pick;        // close the pass: emit and take the best candidate
    } pcbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // issue finished and the compare pipeline drained
        logic best_found;  // the pass found a live candidate
    } pcbs_sts_t;

endpackage

// ----- src/pcbs_ctrl.sv -----
// Controller state machine sequencing load, scan and pick phases.
module pcbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 last,
    input  pcbs_pkg::pcbs_sts_t  sts,
    output pcbs_pkg::pcbs_cmd_t  cmd,
    output logic                 busy
);

    typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_PICK} state_t;

    state_t state_reg;
    logic   busy_reg;

    always_comb
    begin
        cmd.load       = (state_reg == ST_LOAD) && start;
        cmd.pick       = (state_reg == ST_PICK);
        cmd.scan_start = (cmd.load && last) || (cmd.pick && sts.best_found);
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            busy_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (start && last)
                    begin
                        state_reg <= ST_SCAN;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (sts.scan_done)
                        state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (sts.best_found)
                        state_reg <= ST_SCAN;
                    else
                    begin
                        state_reg <= ST_LOAD;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- src/pcbs_dp.sv -----
// Datapath: candidate memory, pipelined overlap test, best-candidate search and result register.
module pcbs_dp #(
    parameter int MAX_CANDIDATES = pcbs_pkg::MAX_CANDIDATES_DEF,
    parameter int COORD_BITS     = pcbs_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcbs_pkg::pcbs_cmd_t           cmd,
    output pcbs_pkg::pcbs_sts_t           sts,
    input  logic                          cfg_we,
    input  logic [pcbs_pkg::THR_W-1:0]    cfg_data,
    input  logic                          has_box,
    input  logic [pcbs_pkg::CLASS_W-1:0]  class_id,
    input  logic [pcbs_pkg::SCORE_W-1:0]  score,
    input  logic [COORD_BITS-1:0]         left,
    input  logic [COORD_BITS-1:0]         top,
    input  logic [COORD_BITS-1:0]         right,
    input  logic [COORD_BITS-1:0]         bottom,
    output logic                          strobe,
    output logic                          kept_valid,
    output logic [pcbs_pkg::CLASS_W-1:0]  kept_class,
    output logic [pcbs_pkg::SCORE_W-1:0]  kept_score,
    output logic [COORD_BITS-1:0]         kept_left,
    output logic [COORD_BITS-1:0]         kept_top,
    output logic [COORD_BITS-1:0]         kept_right,
    output logic [COORD_BITS-1:0]         kept_bottom,
    output logic                          kept_last,
    output logic                          dropped_overflow
);

    localparam int C     = COORD_BITS;
    localparam int IW    = $clog2(MAX_CANDIDATES);
    localparam int NW    = $clog2(MAX_CANDIDATES + 1);
    localparam int SW    = pcbs_pkg::SCORE_W;
    localparam int KW    = pcbs_pkg::CLASS_W;
    localparam int RW    = KW + SW + 4 * C;
    localparam int B_OFF = 0;
    localparam int R_OFF = C;
    localparam int T_OFF = 2 * C;
    localparam int L_OFF = 3 * C;
    localparam int S_OFF = 4 * C;
    localparam int K_OFF = 4 * C + SW;
    localparam int AW    = 2 * C;
    localparam int UW    = 2 * C + 1;
    localparam int PW    = 2 * C + 17;

    logic [RW-1:0] mem [MAX_CANDIDATES];

    logic [pcbs_pkg::THR_W-1:0] thr_reg;
    logic [NW-1:0]              count_reg;
    logic                       ovf_reg;
    logic [MAX_CANDIDATES-1:0]  done_reg;
    logic                       act_reg;
    logic [NW-1:0]              issue_reg;

    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IW-1:0] j1_reg, j2_reg, j3_reg, j4_reg, j5_reg;
    logic [RW-1:0] rec1_reg, rec2_reg, rec3_reg, rec4_reg, rec5_reg;
    logic          hit2_reg, hit3_reg, hit4_reg, hit5_reg;
    logic [C-1:0]  dx2_reg, dy2_reg, wa2_reg, ha2_reg, wb2_reg, hb2_reg;
    logic [AW-1:0] inter3_reg, areaa3_reg, areab3_reg, inter4_reg, inter5_reg;
    logic [UW-1:0] uni4_reg;
    logic [PW-1:0] prod5_reg;

    logic          best_found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [RW-1:0] best_rec_reg;
    logic          a_valid_reg;
    logic [RW-1:0] a_rec_reg;

    logic          strobe_reg, kvalid_reg, klast_reg, kovf_reg;
    logic [RW-1:0] krec_reg;

    // Geometry of the scanned box against the current kept box.
    logic [C-1:0] x1, y1, x2, y2;
    logic         hit1, over5, supp5, better5;

    always_comb
    begin
        x1 = (a_rec_reg[L_OFF +: C] > rec1_reg[L_OFF +: C]) ?
             a_rec_reg[L_OFF +: C] : rec1_reg[L_OFF +: C];
        y1 = (a_rec_reg[T_OFF +: C] > rec1_reg[T_OFF +: C]) ?
             a_rec_reg[T_OFF +: C] : rec1_reg[T_OFF +: C];
        x2 = (a_rec_reg[R_OFF +: C] < rec1_reg[R_OFF +: C]) ?
             a_rec_reg[R_OFF +: C] : rec1_reg[R_OFF +: C];
        y2 = (a_rec_reg[B_OFF +: C] < rec1_reg[B_OFF +: C]) ?
             a_rec_reg[B_OFF +: C] : rec1_reg[B_OFF +: C];
        hit1 = a_valid_reg && (a_rec_reg[K_OFF +: KW] == rec1_reg[K_OFF +: KW])
               && (x2 > x1) && (y2 > y1);
        over5   = {1'b0, inter5_reg, 16'b0} > prod5_reg;
        supp5   = hit5_reg && over5;
        better5 = !done_reg[j5_reg] && !supp5 &&
                  (!best_found_reg || (rec5_reg[S_OFF +: SW] > best_rec_reg[S_OFF +: SW]));
    end

    assign sts.scan_done  = !act_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg;
    assign sts.best_found = best_found_reg;

    // Candidate memory: written while loading, read by the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_box && (count_reg < NW'(MAX_CANDIDATES)))
            mem[count_reg[IW-1:0]] <= {class_id, score, left, top, right, bottom};
    end

    always_ff @(posedge clk)
    begin
        rec1_reg <= mem[issue_reg[IW-1:0]];
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        j1_reg     <= issue_reg[IW-1:0];
        j2_reg     <= j1_reg;
        rec2_reg   <= rec1_reg;
        hit2_reg   <= hit1;
        dx2_reg    <= x2 - x1;
        dy2_reg    <= y2 - y1;
        wa2_reg    <= a_rec_reg[R_OFF +: C] - a_rec_reg[L_OFF +: C];
        ha2_reg    <= a_rec_reg[B_OFF +: C] - a_rec_reg[T_OFF +: C];
        wb2_reg    <= rec1_reg[R_OFF +: C] - rec1_reg[L_OFF +: C];
        hb2_reg    <= rec1_reg[B_OFF +: C] - rec1_reg[T_OFF +: C];
        j3_reg     <= j2_reg;
        rec3_reg   <= rec2_reg;
        hit3_reg   <= hit2_reg;
        inter3_reg <= AW'(dx2_reg) * AW'(dy2_reg);
        areaa3_reg <= AW'(wa2_reg) * AW'(ha2_reg);
        areab3_reg <= AW'(wb2_reg) * AW'(hb2_reg);
        j4_reg     <= j3_reg;
        rec4_reg   <= rec3_reg;
        hit4_reg   <= hit3_reg;
        inter4_reg <= inter3_reg;
        uni4_reg   <= UW'(areaa3_reg) + UW'(areab3_reg) - UW'(inter3_reg);
        j5_reg     <= j4_reg;
        rec5_reg   <= rec4_reg;
        hit5_reg   <= hit4_reg;
        inter5_reg <= inter4_reg;
        prod5_reg  <= PW'(thr_reg) * PW'(uni4_reg);
        if (v5_reg && better5)
        begin
            best_rec_reg <= rec5_reg;
            best_idx_reg <= j5_reg;
        end
        if (cmd.pick && best_found_reg)
            a_rec_reg <= best_rec_reg;
        if (cmd.pick)
            krec_reg <= a_valid_reg ? a_rec_reg : '0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= pcbs_pkg::THR_RESET;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= '0;
            act_reg        <= 1'b0;
            issue_reg      <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            best_found_reg <= 1'b0;
            a_valid_reg    <= 1'b0;
            strobe_reg     <= 1'b0;
            kvalid_reg     <= 1'b0;
            klast_reg      <= 1'b0;
            kovf_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;

            if (cmd.load && has_box)
            begin
                if (count_reg < NW'(MAX_CANDIDATES))
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end

            v1_reg <= act_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (act_reg)
            begin
                issue_reg <= issue_reg + 1'b1;
                if (issue_reg + 1'b1 == count_reg)
                    act_reg <= 1'b0;
            end

            if (v5_reg)
            begin
                if (supp5)
                    done_reg[j5_reg] <= 1'b1;
                if (better5)
                    best_found_reg <= 1'b1;
            end

            strobe_reg <= cmd.pick && (a_valid_reg || !best_found_reg);
            if (cmd.pick)
            begin
                kvalid_reg <= a_valid_reg;
                klast_reg  <= !best_found_reg;
                kovf_reg   <= ovf_reg;
                if (best_found_reg)
                begin
                    a_valid_reg            <= 1'b1;
                    done_reg[best_idx_reg] <= 1'b1;
                end
                else
                begin
                    a_valid_reg <= 1'b0;
                    count_reg   <= '0;
                    ovf_reg     <= 1'b0;
                    done_reg    <= '0;
                end
            end

            if (cmd.scan_start)
            begin
                issue_reg      <= '0;
                act_reg        <= (cmd.load && has_box) || (count_reg != '0);
                best_found_reg <= 1'b0;
            end
        end
    end

    assign strobe           = strobe_reg;
    assign kept_valid       = kvalid_reg;
    assign kept_last        = klast_reg;
    assign dropped_overflow = kovf_reg;
    assign kept_class       = krec_reg[K_OFF +: KW];
    assign kept_score       = krec_reg[S_OFF +: SW];
    assign kept_left        = krec_reg[L_OFF +: C];
    assign kept_top         = krec_reg[T_OFF +: C];
    assign kept_right       = krec_reg[R_OFF +: C];
    assign kept_bottom      = krec_reg[B_OFF +: C];

endmodule

// ----- src/per_class_box_suppression.sv -----
// Top level of the per-class greedy non-maximum suppression block.
//
// Channel    Direction  Handshake                 Contents
// request    in         start / busy              has_box, class_id, score, corners, last
// result     out        strobe (one cycle)        kept_* fields, dropped_overflow
// config     in         cfg_valid / cfg_ready     cfg_data = IoU threshold, Q0.16
//
// While loading, one request is accepted every cycle. The request marked last
// starts suppression: each pass streams every stored candidate through a
// five-stage compare pipeline; a frame with K kept boxes takes K + 1 passes,
// and busy falls after the final pass, which finds no live candidate.
// Reset clears all control state and sets the threshold to one half.
// Results cannot be stalled; each appears for exactly one cycle on strobe.
module per_class_box_suppression #(
    parameter int MAX_CANDIDATES = pcbs_pkg::MAX_CANDIDATES_DEF,
    parameter int COORD_BITS     = pcbs_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcbs_pkg::THR_W-1:0]    cfg_data,
    input  logic                          has_box,
    input  logic [pcbs_pkg::CLASS_W-1:0]  class_id,
    input  logic [pcbs_pkg::SCORE_W-1:0]  score,
    input  logic [COORD_BITS-1:0]         left,
    input  logic [COORD_BITS-1:0]         top,
    input  logic [COORD_BITS-1:0]         right,
    input  logic [COORD_BITS-1:0]         bottom,
    input  logic                          last,
    output logic                          strobe,
    output logic                          kept_valid,
    output logic [pcbs_pkg::CLASS_W-1:0]  kept_class,
    output logic [pcbs_pkg::SCORE_W-1:0]  kept_score,
    output logic [COORD_BITS-1:0]         kept_left,
    output logic [COORD_BITS-1:0]         kept_top,
    output logic [COORD_BITS-1:0]         kept_right,
    output logic [COORD_BITS-1:0]         kept_bottom,
    output logic                          kept_last,
    output logic                          dropped_overflow
);

    pcbs_pkg::pcbs_cmd_t cmd;
    pcbs_pkg::pcbs_sts_t sts;

    // The threshold is only rewritten between frames.
    assign cfg_ready = !busy;

    pcbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pcbs_dp #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COORD_BITS     (COORD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .has_box          (has_box),
        .class_id         (class_id),
        .score            (score),
        .left             (left),
        .top              (top),
        .right            (right),
        .bottom           (bottom),
        .strobe           (strobe),
        .kept_valid       (kept_valid),
        .kept_class       (kept_class),
        .kept_score       (kept_score),
        .kept_left        (kept_left),
        .kept_top         (kept_top),
        .kept_right       (kept_right),
        .kept_bottom      (kept_bottom),
        .kept_last        (kept_last),
        .dropped_overflow (dropped_overflow)
    );

    // An empty-frame result is always the final one of its frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !kept_valid |-> kept_last)
        else $error("invalid result without kept_last");

    // The final result of a frame coincides with the return to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kept_last |-> !busy)
        else $error("busy still high at end of frame");

    // A request carrying last begins suppression.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last |=> busy)
        else $error("suppression did not start after last request");

    // Results only come out of the suppression phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result produced while loading");

endmodule
